FILE: design/sin_cos_turns_polynomial_defines.svh
// assertion helpers shared by the sine/cosine pipeline
// both expect clk and rst in scope
`ifndef SIN_COS_TURNS_POLYNOMIAL_DEFINES_SVH
`define SIN_COS_TURNS_POLYNOMIAL_DEFINES_SVH

// same-cycle implication
`define SCT_ASSERT_COMB(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int PHASE_BITS    = 24;
  localparam int OUT_FRAC_BITS = 16;
  localparam int PHASE_W       = 24;
  localparam int OUT_W         = 18;
  localparam int Q_W           = 32;
  localparam int FRAC          = 30;
  localparam int PROD_W        = 2 * Q_W;
  localparam int unsigned OUT_SH = FRAC - OUT_FRAC_BITS;

  typedef logic signed [Q_W-1:0]    q30_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  // q30 constants
  localparam q30_t Q_ONE   = 32'sd1073741824;
  localparam q30_t HALF_PI = 32'sd1686629713;
  localparam q30_t C0      = 32'sd1324675879;
  localparam q30_t C1      = 32'sd272375560;
  localparam q30_t C2      = 32'sd22401992;
  localparam q30_t C3      = 32'sd987048;
  localparam q30_t S0      = 32'sd441558626;
  localparam q30_t S1      = 32'sd54475112;
  localparam q30_t S2      = 32'sd3200285;
  localparam q30_t S3      = 32'sd109672;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    quad_t quad;
    q30_t  r;
  } front_t;

  typedef struct packed {
    quad_t quad;
    q30_t  cv;
    q30_t  sv;
  } poly_t;

  // arithmetic shift right, round to nearest, ties away from zero
  function automatic prod_t round_shr(input prod_t p, input int unsigned sh);
    prod_t bias;
    prod_t fix;
    bias = (prod_t'(1) << sh) >> 1;
    fix  = (sh != 0 && p[PROD_W-1]) ? prod_t'(1) : prod_t'(0);
    return (p + bias - fix) >>> sh;
  endfunction

  // q30 product, rounded back to q30
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    prod_t p;
    prod_t s;
    p = a * b;
    s = round_shr(p, FRAC);
    return s[Q_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/sct_phase_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sct_phase_if import sct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

`default_nettype wire

FILE: design/sct_sincos_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sct_sincos_if import sct_pkg::*; ();
  logic valid;
  logic ready;
  out_t sine;
  out_t cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

`default_nettype wire

FILE: design/sin_cos_turns_polynomial.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sin_cos_turns_polynomial_defines.svh"

// channel   dir  payload                      meaning
// angle     in   phase[23:0] unsigned          angle in turns, full circle = 2^PHASE_BITS
// result    out  sine[17:0], cosine[17:0] s    Q1.OUT_FRAC_BITS, clamped to +-1.0
//
// one transaction per cycle sustained while result.ready stays high; angle to result passes through
// 1 phase split stage, 7 polynomial stages and 2 output stages, all registered
// the polynomial stages follow the chain of dependent q30 multiplies
// rst is synchronous and clears only the valid bits; data registers are not reset
// each stage advances when it is empty or the next stage advances, so bubbles
// collapse under back-pressure and a stalled transaction is held, not lost or repeated

module sin_cos_turns_polynomial import sct_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  sct_phase_if.sink    angle,
  sct_sincos_if.source result
);

  // phase split -> polynomial pipeline
  logic   front_valid;
  logic   front_ready;
  front_t front_data;

  // polynomial pipeline -> quadrant map and output formatting
  logic   poly_valid;
  logic   poly_ready;
  poly_t  poly_data;

  // quadrant and remainder r in [-0.5, 0.5) quarter turns, q30
  sct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (angle.valid),
    .in_ready  (angle.ready),
    .phase     (angle.phase),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out       (front_data)
  );

  // even degree-8 cosine and odd degree-9 sine series with pi/2 folded in
  sct_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in        (front_data),
    .out_valid (poly_valid),
    .out_ready (poly_ready),
    .out       (poly_data)
  );

  // swap/negate by quadrant, round to output precision, clamp to +-1.0
  sct_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poly_valid),
    .in_ready  (poly_ready),
    .in        (poly_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sine      (result.sine),
    .cosine    (result.cosine)
  );

  // an accepted angle always lands in the first stage
  `SCT_ASSERT_NEXT(a_accept_lands, angle.valid && angle.ready, front_valid, "accepted angle did not enter the pipeline")

  // the input only stalls when the whole pipeline is full and the result is held off
  `SCT_ASSERT_COMB(a_stall_only_backpressure, !angle.ready, result.valid && !result.ready, "input stalled without output back-pressure")

  // a stalled input means every stage ahead of the output is occupied
  `SCT_ASSERT_COMB(a_front_full_on_stall, !angle.ready, front_valid && poly_valid, "input stalled with a bubble in the pipeline")

endmodule

`default_nettype wire

FILE: design/sct_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_front import sct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PHASE_W-1:0] phase,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output front_t                  out
);

  localparam logic [PHASE_BITS-1:0] EIGHTH = PHASE_BITS'(1) << (PHASE_BITS - 3);
  localparam int R_SH = Q_W - PHASE_BITS;

  logic [PHASE_BITS-1:0] ph;
  logic [PHASE_BITS-1:0] u;
  q30_t                  rem;
  logic                  en;
  logic                  vld;
  front_t                out_next;

  assign ph  = PHASE_BITS'(phase);
  assign u   = ph + EIGHTH;
  assign rem = q30_t'(u[PHASE_BITS-3:0]) - q30_t'(EIGHTH);

  always_comb begin
    out_next.quad = quad_t'(u[PHASE_BITS-1 -: 2]);
    out_next.r    = rem <<< R_SH;
  end

  assign en        = !vld || out_ready;
  assign in_ready  = en;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/sct_poly.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_poly import sct_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire front_t in,
  output logic        out_valid,
  input  wire logic   out_ready,
  output poly_t       out
);

  localparam int NST = 7;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // stage 1: r^2
  quad_t quad1; q30_t r_1; q30_t r2_1;
  // stage 2: r^4
  quad_t quad2; q30_t r_2; q30_t r2_2; q30_t r4_2;
  // stage 3: inner terms
  quad_t quad3; q30_t r_3; q30_t r2_3; q30_t r4_3;
  q30_t  xc0_3; q30_t xc1_3; q30_t xs0_3; q30_t xs1_3;
  // stage 4: outer products
  quad_t quad4; q30_t r_4;
  q30_t  ca_4; q30_t cb_4; q30_t sa_4; q30_t sb_4;
  // stage 5: sums
  quad_t quad5; q30_t r_5; q30_t cv_5; q30_t sp_5;
  // stage 6: r * sine series
  quad_t quad6; q30_t cv_6; q30_t t_6;
  // stage 7: scale by pi/2
  quad_t quad7; q30_t cv_7; q30_t sv_7;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad1 <= in.quad;
      r_1   <= in.r;
      r2_1  <= qmul(in.r, in.r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quad2 <= quad1;
      r_2   <= r_1;
      r2_2  <= r2_1;
      r4_2  <= qmul(r2_1, r2_1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      quad3 <= quad2;
      r_3   <= r_2;
      r2_3  <= r2_2;
      r4_3  <= r4_2;
      xc0_3 <= C0 + qmul(r4_2, C2);
      xc1_3 <= C1 + qmul(r4_2, C3);
      xs0_3 <= S0 + qmul(r4_2, S2);
      xs1_3 <= S1 + qmul(r4_2, S3);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      quad4 <= quad3;
      r_4   <= r_3;
      ca_4  <= qmul(r2_3, xc0_3);
      cb_4  <= qmul(r4_3, xc1_3);
      sa_4  <= qmul(r2_3, xs0_3);
      sb_4  <= qmul(r4_3, xs1_3);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      quad5 <= quad4;
      r_5   <= r_4;
      cv_5  <= Q_ONE - ca_4 + cb_4;
      sp_5  <= Q_ONE - sa_4 + sb_4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      quad6 <= quad5;
      cv_6  <= cv_5;
      t_6   <= qmul(r_5, sp_5);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      quad7 <= quad6;
      cv_7  <= cv_6;
      sv_7  <= qmul(HALF_PI, t_6);
    end
  end

  always_comb begin
    out.quad = quad7;
    out.cv   = cv_7;
    out.sv   = sv_7;
  end

endmodule

`default_nettype wire

FILE: design/sct_out.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sin_cos_turns_polynomial_defines.svh"

module sct_out import sct_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire poly_t in,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       sine,
  output out_t       cosine
);

  // 0.7 in q30, below cos(pi/4) with margin
  localparam q30_t  MAG_TH = 32'sd751619276;
  localparam prod_t LIM    = prod_t'(1) <<< OUT_FRAC_BITS;

  logic [1:0] vld;
  logic [1:0] en;
  q30_t       so1;
  q30_t       co1;
  q30_t       so_next;
  q30_t       co_next;

  function automatic out_t to_out(input q30_t q);
    prod_t v;
    v = round_shr(prod_t'(q), OUT_SH);
    if (v > LIM) begin
      v = LIM;
    end
    if (v < -LIM) begin
      v = -LIM;
    end
    return v[OUT_W-1:0];
  endfunction

  // quadrant swap and negate
  always_comb begin
    case (in.quad)
      QUAD_0: begin so_next = in.sv;  co_next = in.cv;  end
      QUAD_1: begin so_next = in.cv;  co_next = -in.sv; end
      QUAD_2: begin so_next = -in.sv; co_next = -in.cv; end
      QUAD_3: begin so_next = -in.cv; co_next = in.sv;  end
      default: begin so_next = in.sv; co_next = in.cv;  end
    endcase
  end

  assign en[1]     = !vld[1] || out_ready;
  assign en[0]     = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      if (en[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      so1 <= so_next;
      co1 <= co_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sine   <= to_out(so1);
      cosine <= to_out(co1);
    end
  end

  // one of the two is always the cosine branch near its peak
  `SCT_ASSERT_COMB(a_one_side_large, vld[0], so1 >= MAG_TH || so1 <= -MAG_TH || co1 >= MAG_TH || co1 <= -MAG_TH, "neither sine nor cosine near full scale")

endmodule

`default_nettype wire
